// File: design/sgi_pkg.sv
// Package: shared widths and payload types for the segment intersection block.
`default_nettype none
package sgi_pkg;

  localparam int COORD_BITS = 16;
  localparam int CROSS_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * COORD_BITS + 2;
  localparam int DEN_W      = 2 * COORD_BITS + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;
  } sgi_in_t;

  typedef struct packed {
    logic                         hit;
    logic signed [CROSS_BITS-1:0] cross_x;
    logic signed [CROSS_BITS-1:0] cross_y;
  } sgi_out_t;

  // per-item control that travels with the data
  typedef struct packed {
    logic hit;
    logic neg_x;
    logic neg_y;
  } sgi_ctl_t;

endpackage
`default_nettype wire

// File: design/sgi_front.sv
// Front pipeline: differences, cross products, side test and ratio setup.
`default_nettype none
module sgi_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sgi_pkg::sgi_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sgi_pkg::sgi_ctl_t                out_ctl,
  output logic [sgi_pkg::DEN_W-1:0]        out_num,
  output logic [sgi_pkg::DEN_W-1:0]        out_den,
  output logic [sgi_pkg::COORD_BITS-1:0]   out_mag_x,
  output logic [sgi_pkg::COORD_BITS-1:0]   out_mag_y,
  output logic signed [sgi_pkg::COORD_BITS-1:0] out_start_x,
  output logic signed [sgi_pkg::COORD_BITS-1:0] out_start_y
);
  import sgi_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: differences
  logic signed [DIFF_W-1:0] rx1_r, ry1_r, qx1_r, qy1_r, sx1_r, sy1_r, tx1_r, ty1_r;
  logic signed [COORD_BITS-1:0] stx1_r, sty1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      rx1_r  <= DIFF_W'(in_data.first_end_x) - DIFF_W'(in_data.first_start_x);
      ry1_r  <= DIFF_W'(in_data.first_end_y) - DIFF_W'(in_data.first_start_y);
      qx1_r  <= DIFF_W'(in_data.second_start_x) - DIFF_W'(in_data.first_start_x);
      qy1_r  <= DIFF_W'(in_data.second_start_y) - DIFF_W'(in_data.first_start_y);
      sx1_r  <= DIFF_W'(in_data.second_end_x) - DIFF_W'(in_data.second_start_x);
      sy1_r  <= DIFF_W'(in_data.second_end_y) - DIFF_W'(in_data.second_start_y);
      tx1_r  <= DIFF_W'(in_data.second_end_x) - DIFF_W'(in_data.first_start_x);
      ty1_r  <= DIFF_W'(in_data.second_end_y) - DIFF_W'(in_data.first_start_y);
      stx1_r <= in_data.first_start_x;
      sty1_r <= in_data.first_start_y;
    end
  end

  // stage 2: eight products, direction magnitudes
  logic signed [PROD_W-1:0] p_rq1_r, p_rq2_r, p_rt1_r, p_rt2_r;
  logic signed [PROD_W-1:0] p_rs1_r, p_rs2_r, p_qs1_r, p_qs2_r;
  logic signed [COORD_BITS-1:0] stx2_r, sty2_r;
  logic [COORD_BITS-1:0] magx2_r, magy2_r;
  logic negx2_r, negy2_r;
  logic signed [DIFF_W-1:0] absx, absy;

  always_comb begin
    absx = rx1_r[DIFF_W-1] ? -rx1_r : rx1_r;
    absy = ry1_r[DIFF_W-1] ? -ry1_r : ry1_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p_rq1_r <= PROD_W'(rx1_r) * PROD_W'(qy1_r);
      p_rq2_r <= PROD_W'(ry1_r) * PROD_W'(qx1_r);
      p_rt1_r <= PROD_W'(rx1_r) * PROD_W'(ty1_r);
      p_rt2_r <= PROD_W'(ry1_r) * PROD_W'(tx1_r);
      p_rs1_r <= PROD_W'(rx1_r) * PROD_W'(sy1_r);
      p_rs2_r <= PROD_W'(ry1_r) * PROD_W'(sx1_r);
      p_qs1_r <= PROD_W'(qx1_r) * PROD_W'(sy1_r);
      p_qs2_r <= PROD_W'(qy1_r) * PROD_W'(sx1_r);
      magx2_r <= absx[COORD_BITS-1:0];
      magy2_r <= absy[COORD_BITS-1:0];
      negx2_r <= rx1_r[DIFF_W-1];
      negy2_r <= ry1_r[DIFF_W-1];
      stx2_r  <= stx1_r;
      sty2_r  <= sty1_r;
    end
  end

  // stage 3: side values, denominator and numerator
  logic signed [PROD_W-1:0] da3_r, db3_r, den3_r, nu3_r;
  logic signed [COORD_BITS-1:0] stx3_r, sty3_r;
  logic [COORD_BITS-1:0] magx3_r, magy3_r;
  logic negx3_r, negy3_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      da3_r   <= p_rq1_r - p_rq2_r;
      db3_r   <= p_rt1_r - p_rt2_r;
      den3_r  <= p_rs1_r - p_rs2_r;
      nu3_r   <= p_qs1_r - p_qs2_r;
      magx3_r <= magx2_r;
      magy3_r <= magy2_r;
      negx3_r <= negx2_r;
      negy3_r <= negy2_r;
      stx3_r  <= stx2_r;
      sty3_r  <= sty2_r;
    end
  end

  // stage 4: sign test, normalize denominator to positive, range check
  logic signed [PROD_W-1:0] d4, n4;
  logic side_diff, hit4;

  always_comb begin
    side_diff = (da3_r[PROD_W-1] != db3_r[PROD_W-1]) || ((da3_r == '0) != (db3_r == '0));
    d4 = den3_r[PROD_W-1] ? -den3_r : den3_r;
    n4 = den3_r[PROD_W-1] ? -nu3_r : nu3_r;
    hit4 = side_diff && !n4[PROD_W-1] && (n4 != '0) && (n4 < d4);
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_ctl.hit   <= hit4;
      out_ctl.neg_x <= negx3_r;
      out_ctl.neg_y <= negy3_r;
      out_num       <= n4[DEN_W-1:0];
      out_den       <= d4[DEN_W-1:0];
      out_mag_x     <= magx3_r;
      out_mag_y     <= magy3_r;
      out_start_x   <= stx3_r;
      out_start_y   <= sty3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign out_valid = v4_r;

endmodule
`default_nettype wire

// File: design/sgi_mul.sv
// Two-stage split multiplier: ratio numerator times direction magnitude.
`default_nettype none
module sgi_mul #(
  parameter int EXTRA_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  sgi_pkg::sgi_ctl_t                     in_ctl,
  input  logic [sgi_pkg::DEN_W-1:0]             in_num,
  input  logic [sgi_pkg::DEN_W-1:0]             in_den,
  input  logic [sgi_pkg::COORD_BITS-1:0]        in_mag_x,
  input  logic [sgi_pkg::COORD_BITS-1:0]        in_mag_y,
  input  logic signed [sgi_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [sgi_pkg::COORD_BITS-1:0] in_start_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output sgi_pkg::sgi_ctl_t                     out_ctl,
  output logic [sgi_pkg::DEN_W+sgi_pkg::COORD_BITS+EXTRA_FRAC_BITS-1:0] out_prod_x,
  output logic [sgi_pkg::DEN_W+sgi_pkg::COORD_BITS+EXTRA_FRAC_BITS-1:0] out_prod_y,
  output logic [sgi_pkg::DEN_W-1:0]             out_den,
  output logic signed [sgi_pkg::COORD_BITS-1:0] out_start_x,
  output logic signed [sgi_pkg::COORD_BITS-1:0] out_start_y
);
  import sgi_pkg::*;

  localparam int LO_W = DEN_W / 2;
  localparam int HI_W = DEN_W - LO_W;
  localparam int PW   = DEN_W + COORD_BITS;
  localparam int MW   = PW + EXTRA_FRAC_BITS;

  logic va_r, vb_r, rdya, rdyb;
  assign rdyb     = !vb_r || out_ready;
  assign rdya     = !va_r || rdyb;
  assign in_ready = rdya;

  logic [LO_W+COORD_BITS-1:0] plx_r, ply_r;
  logic [HI_W+COORD_BITS-1:0] phx_r, phy_r;
  sgi_ctl_t ctla_r;
  logic [DEN_W-1:0] dena_r;
  logic signed [COORD_BITS-1:0] stxa_r, stya_r;

  always_ff @(posedge clk) begin
    if (rdya) begin
      plx_r  <= (LO_W+COORD_BITS)'(in_num[LO_W-1:0]) * (LO_W+COORD_BITS)'(in_mag_x);
      ply_r  <= (LO_W+COORD_BITS)'(in_num[LO_W-1:0]) * (LO_W+COORD_BITS)'(in_mag_y);
      phx_r  <= (HI_W+COORD_BITS)'(in_num[DEN_W-1:LO_W]) * (HI_W+COORD_BITS)'(in_mag_x);
      phy_r  <= (HI_W+COORD_BITS)'(in_num[DEN_W-1:LO_W]) * (HI_W+COORD_BITS)'(in_mag_y);
      ctla_r <= in_ctl;
      dena_r <= in_den;
      stxa_r <= in_start_x;
      stya_r <= in_start_y;
    end
  end

  logic [PW-1:0] sumx, sumy;
  always_comb begin
    sumx = PW'(plx_r) + (PW'(phx_r) << LO_W);
    sumy = PW'(ply_r) + (PW'(phy_r) << LO_W);
  end

  always_ff @(posedge clk) begin
    if (rdyb) begin
      out_prod_x  <= MW'(sumx) << EXTRA_FRAC_BITS;
      out_prod_y  <= MW'(sumy) << EXTRA_FRAC_BITS;
      out_ctl     <= ctla_r;
      out_den     <= dena_r;
      out_start_x <= stxa_r;
      out_start_y <= stya_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdya) va_r <= in_valid;
      if (rdyb) vb_r <= va_r;
    end
  end

  assign out_valid = vb_r;

endmodule
`default_nettype wire

// File: design/sgi_div.sv
// Pipelined restoring divider, one quotient bit per stage, x and y lanes.
`default_nettype none
module sgi_div #(
  parameter int EXTRA_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  sgi_pkg::sgi_ctl_t                     in_ctl,
  input  logic [sgi_pkg::DEN_W+sgi_pkg::COORD_BITS+EXTRA_FRAC_BITS-1:0] in_prod_x,
  input  logic [sgi_pkg::DEN_W+sgi_pkg::COORD_BITS+EXTRA_FRAC_BITS-1:0] in_prod_y,
  input  logic [sgi_pkg::DEN_W-1:0]             in_den,
  input  logic signed [sgi_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [sgi_pkg::COORD_BITS-1:0] in_start_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output sgi_pkg::sgi_ctl_t                     out_ctl,
  output logic [sgi_pkg::COORD_BITS+EXTRA_FRAC_BITS-1:0] out_quo_x,
  output logic [sgi_pkg::COORD_BITS+EXTRA_FRAC_BITS-1:0] out_quo_y,
  output logic [sgi_pkg::DEN_W-1:0]             out_rem_x,
  output logic [sgi_pkg::DEN_W-1:0]             out_rem_y,
  output logic [sgi_pkg::DEN_W-1:0]             out_den,
  output logic signed [sgi_pkg::COORD_BITS-1:0] out_start_x,
  output logic signed [sgi_pkg::COORD_BITS-1:0] out_start_y
);
  import sgi_pkg::*;

  localparam int QB = COORD_BITS + EXTRA_FRAC_BITS;
  localparam int MW = DEN_W + QB;

  // index 0 is the input side, index k+1 the register of stage k
  logic                    v_r   [QB+1];
  logic                    rdy   [QB+1];
  sgi_ctl_t                ctl_r [QB+1];
  logic [DEN_W-1:0]        den_r [QB+1];
  logic [DEN_W-1:0]        remx_r[QB+1], remy_r[QB+1];
  logic [QB-1:0]           lowx_r[QB+1], lowy_r[QB+1];
  logic [QB-1:0]           qx_r  [QB+1], qy_r  [QB+1];
  logic signed [COORD_BITS-1:0] stx_r[QB+1], sty_r[QB+1];

  always_comb begin
    v_r[0]    = in_valid;
    ctl_r[0]  = in_ctl;
    den_r[0]  = in_den;
    remx_r[0] = in_prod_x[MW-1:QB];
    remy_r[0] = in_prod_y[MW-1:QB];
    lowx_r[0] = in_prod_x[QB-1:0];
    lowy_r[0] = in_prod_y[QB-1:0];
    qx_r[0]   = '0;
    qy_r[0]   = '0;
    stx_r[0]  = in_start_x;
    sty_r[0]  = in_start_y;
  end

  assign rdy[QB]  = !v_r[QB] || out_ready;
  assign in_ready = rdy[0];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DEN_W:0] trx, try_, subx, suby;
    logic gex, gey;

    if (k > 0) begin : g_rdy
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end else begin : g_rdy0
      assign rdy[0] = rdy[1];
    end

    always_comb begin
      trx  = {remx_r[k], lowx_r[k][QB-1]};
      try_ = {remy_r[k], lowy_r[k][QB-1]};
      subx = trx - {1'b0, den_r[k]};
      suby = try_ - {1'b0, den_r[k]};
      gex  = trx >= {1'b0, den_r[k]};
      gey  = try_ >= {1'b0, den_r[k]};
    end

    always_ff @(posedge clk) begin
      if (rdy[k+1]) begin
        remx_r[k+1] <= gex ? subx[DEN_W-1:0] : trx[DEN_W-1:0];
        remy_r[k+1] <= gey ? suby[DEN_W-1:0] : try_[DEN_W-1:0];
        lowx_r[k+1] <= lowx_r[k] << 1;
        lowy_r[k+1] <= lowy_r[k] << 1;
        qx_r[k+1]   <= {qx_r[k][QB-2:0], gex};
        qy_r[k+1]   <= {qy_r[k][QB-2:0], gey};
        ctl_r[k+1]  <= ctl_r[k];
        den_r[k+1]  <= den_r[k];
        stx_r[k+1]  <= stx_r[k];
        sty_r[k+1]  <= sty_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (rdy[k+1]) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  assign out_valid   = v_r[QB];
  assign out_ctl     = ctl_r[QB];
  assign out_quo_x   = qx_r[QB];
  assign out_quo_y   = qy_r[QB];
  assign out_rem_x   = remx_r[QB];
  assign out_rem_y   = remy_r[QB];
  assign out_den     = den_r[QB];
  assign out_start_x = stx_r[QB];
  assign out_start_y = sty_r[QB];

endmodule
`default_nettype wire

// File: design/segment_intersection.sv
// Top level: 2-D segment crossing test with fixed-point crossing point.
//
// Usage:
//   in_*  : one transfer carries both segments (sgi_in_t), taken when
//           in_valid is high and in_stall is low.
//   out_* : one transfer per input item (sgi_out_t): hit flag and the
//           crossing point scaled by 2^EXTRA_FRAC_BITS, rounded to nearest
//           (ties up). Both coordinates are zero when there is no hit.
// Throughput: one item per cycle, sustained while out_stall is low.
// Pipeline: four front stages (differences, products, cross terms, side
//   test), two multiplier stages, one divider stage per quotient bit, one
//   output stage. The divider depth sets the latency.
// Reset: rst_n low clears all valid bits; the pipeline comes up empty.
// Stall: each stage advances when its successor has room, so bubbles are
//   squeezed out; with out_stall held, the pipe fills up and only then
//   raises in_stall. Nothing is dropped or duplicated.
`default_nettype none
module segment_intersection #(
  parameter int EXTRA_FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sgi_pkg::sgi_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sgi_pkg::sgi_out_t out_data
);
  import sgi_pkg::*;

  localparam int QB = COORD_BITS + EXTRA_FRAC_BITS;
  localparam int MW = DEN_W + QB;
  localparam int SW = (QB + 2 > CROSS_BITS) ? QB + 2 : CROSS_BITS;

  // front -> multiplier
  logic             f_valid, f_ready;
  sgi_ctl_t         f_ctl;
  logic [DEN_W-1:0] f_num, f_den;
  logic [COORD_BITS-1:0] f_magx, f_magy;
  logic signed [COORD_BITS-1:0] f_stx, f_sty;
  logic             front_ready;

  sgi_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (front_ready),
    .in_data     (in_data),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_ctl     (f_ctl),
    .out_num     (f_num),
    .out_den     (f_den),
    .out_mag_x   (f_magx),
    .out_mag_y   (f_magy),
    .out_start_x (f_stx),
    .out_start_y (f_sty)
  );

  assign in_stall = !front_ready;

  // multiplier -> divider
  logic             m_valid, m_ready;
  sgi_ctl_t         m_ctl;
  logic [MW-1:0]    m_px, m_py;
  logic [DEN_W-1:0] m_den;
  logic signed [COORD_BITS-1:0] m_stx, m_sty;

  sgi_mul #(.EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)) u_mul (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (f_valid),
    .in_ready    (f_ready),
    .in_ctl      (f_ctl),
    .in_num      (f_num),
    .in_den      (f_den),
    .in_mag_x    (f_magx),
    .in_mag_y    (f_magy),
    .in_start_x  (f_stx),
    .in_start_y  (f_sty),
    .out_valid   (m_valid),
    .out_ready   (m_ready),
    .out_ctl     (m_ctl),
    .out_prod_x  (m_px),
    .out_prod_y  (m_py),
    .out_den     (m_den),
    .out_start_x (m_stx),
    .out_start_y (m_sty)
  );

  // divider -> output stage
  logic             d_valid, d_ready;
  sgi_ctl_t         d_ctl;
  logic [QB-1:0]    d_qx, d_qy;
  logic [DEN_W-1:0] d_rx, d_ry, d_den;
  logic signed [COORD_BITS-1:0] d_stx, d_sty;

  sgi_div #(.EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (m_valid),
    .in_ready    (m_ready),
    .in_ctl      (m_ctl),
    .in_prod_x   (m_px),
    .in_prod_y   (m_py),
    .in_den      (m_den),
    .in_start_x  (m_stx),
    .in_start_y  (m_sty),
    .out_valid   (d_valid),
    .out_ready   (d_ready),
    .out_ctl     (d_ctl),
    .out_quo_x   (d_qx),
    .out_quo_y   (d_qy),
    .out_rem_x   (d_rx),
    .out_rem_y   (d_ry),
    .out_den     (d_den),
    .out_start_x (d_stx),
    .out_start_y (d_sty)
  );

  // Rounding: with P = num*|dir|*2^E = Q*den + R, a positive direction
  // rounds up when 2R >= den, a negative one when 2R > den (floor of the
  // negated value, ties toward plus infinity).
  logic             out_valid_r;
  sgi_out_t         out_data_r;
  logic             upx, upy;
  logic signed [SW-1:0] magx, magy, offx, offy, sumx, sumy;

  always_comb begin
    upx  = d_ctl.neg_x ? ({d_rx, 1'b0} > {1'b0, d_den}) : ({d_rx, 1'b0} >= {1'b0, d_den});
    upy  = d_ctl.neg_y ? ({d_ry, 1'b0} > {1'b0, d_den}) : ({d_ry, 1'b0} >= {1'b0, d_den});
    magx = SW'({1'b0, d_qx}) + SW'({1'b0, upx});
    magy = SW'({1'b0, d_qy}) + SW'({1'b0, upy});
    offx = d_ctl.neg_x ? -magx : magx;
    offy = d_ctl.neg_y ? -magy : magy;
    sumx = (SW'(d_stx) <<< EXTRA_FRAC_BITS) + offx;
    sumy = (SW'(d_sty) <<< EXTRA_FRAC_BITS) + offy;
  end

  assign d_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (d_ready) begin
      out_data_r.hit     <= d_ctl.hit;
      out_data_r.cross_x <= d_ctl.hit ? sumx[CROSS_BITS-1:0] : '0;
      out_data_r.cross_y <= d_ctl.hit ? sumy[CROSS_BITS-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (d_ready) begin
      out_valid_r <= d_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: design/sgi_checker.sv
// Port-level checker for segment_intersection, with its bind.
`default_nettype none
module sgi_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input sgi_pkg::sgi_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input sgi_pkg::sgi_out_t out_data
);
  import sgi_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a stalled input transfer stays put until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // no crossing means a zero point
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.cross_x == '0 && out_data.cross_y == '0)
    else $error("miss with nonzero point");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // the pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind segment_intersection sgi_checker u_sgi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// File: dv/tb_segment_intersection.sv
// Testbench for segment_intersection: directed and random segment pairs checked against a local predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_segment_intersection;
  import sgi_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = 7 + COORD_BITS + FRAC;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sgi_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sgi_out_t out_data;

  segment_intersection #(.EXTRA_FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sgi_in_t  pending_pairs[$];
  sgi_out_t expected_crossings[$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       stimulus_done = 1'b0;
  bit       in_taken = 1'b0;

  function automatic void add_pair(sgi_in_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  // Crossing coordinate: start*2^F + round(dir*nu/den*2^F), ties toward +inf.
  // All terms are exact in 128-bit signed arithmetic.
  function automatic logic signed [CROSS_BITS-1:0] crossing_coord(
      longint start, longint dir, logic signed [127:0] nu, logic signed [127:0] den);
    logic signed [127:0] num, quo;
    num = (nu * dir) <<< (FRAC + 1);
    num = num + den;
    quo = num / (2 * den);
    if (num < 0 && quo * (2 * den) != num) quo = quo - 1;
    return CROSS_BITS'(quo + (start <<< FRAC));
  endfunction

  function automatic logic signed [127:0] cross2(longint ax, longint ay,
                                                 longint bx, longint by);
    logic signed [127:0] a, b;
    a = ax; a = a * by;
    b = ay; b = b * bx;
    return a - b;
  endfunction

  function automatic int sgn(logic signed [127:0] v);
    return v < 0 ? -1 : (v == 0 ? 0 : 1);
  endfunction

  function automatic sgi_out_t predict_crossing(sgi_in_t p);
    sgi_out_t r;
    longint s1x, s1y, rx, ry, qx, qy, sx, sy;
    logic signed [127:0] da, db, den, nu;
    r = '0;
    s1x = p.first_start_x; s1y = p.first_start_y;
    rx = longint'(p.first_end_x) - s1x; ry = longint'(p.first_end_y) - s1y;
    qx = longint'(p.second_start_x) - s1x; qy = longint'(p.second_start_y) - s1y;
    sx = longint'(p.second_end_x) - p.second_start_x;
    sy = longint'(p.second_end_y) - p.second_start_y;
    da = cross2(rx, ry, qx, qy);
    db = cross2(rx, ry, longint'(p.second_end_x) - s1x, longint'(p.second_end_y) - s1y);
    den = cross2(rx, ry, sx, sy);
    nu = cross2(qx, qy, sx, sy);
    if (sgn(da) == sgn(db)) return r;
    if (den < 0) begin
      den = -den;
      nu = -nu;
    end
    if (nu <= 0 || nu >= den) return r;
    r.hit = 1'b1;
    r.cross_x = crossing_coord(s1x, rx, nu, den);
    r.cross_y = crossing_coord(s1y, ry, nu, den);
    return r;
  endfunction

  function automatic logic [15:0] pick_coord(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sgi_in_t pair_of(int a, int b, int c, int d,
                                      int e, int f, int g, int h);
    sgi_in_t p;
    p = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h)};
    return p;
  endfunction

  // Mostly crossing pairs: second segment built around a point near the first.
  function automatic sgi_in_t random_pair();
    sgi_in_t p;
    int mode, m;
    mode = $urandom_range(0, 9);
    m = $urandom_range(0, 3);
    if (mode < 6) begin
      int ax, ay, bx, by, px, py, dx, dy, sc;
      sc = (m == 0) ? 60 : (m == 1 ? 2000 : 15000);
      ax = $urandom_range(0, 2 * sc) - sc; ay = $urandom_range(0, 2 * sc) - sc;
      bx = $urandom_range(0, 2 * sc) - sc; by = $urandom_range(0, 2 * sc) - sc;
      px = (ax + bx) / 2; py = (ay + by) / 2;
      dx = $urandom_range(0, 2 * sc) - sc; dy = $urandom_range(0, 2 * sc) - sc;
      p = pair_of(ax, ay, bx, by, px + dx, py + dy, px - dx, py - dy);
    end else if (mode < 8) begin
      p = {pick_coord(m), pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)),
           pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)),
           pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)),
           pick_coord($urandom_range(0, 3))};
    end else begin
      p = sgi_in_t'({$urandom, $urandom, $urandom, $urandom});
    end
    return p;
  endfunction

  initial begin
    // crossing in the middle, X shape
    add_pair(pair_of(-100, 0, 100, 0, 0, -50, 0, 50));
    // zero-length first segment
    add_pair(pair_of(5, 5, 5, 5, 0, 0, 10, 10));
    // parallel and collinear
    add_pair(pair_of(0, 0, 10, 0, 0, 1, 10, 1));
    add_pair(pair_of(0, 0, 10, 0, -5, 0, 20, 0));
    // second segment touching the first's line with one end
    add_pair(pair_of(0, 0, 10, 0, 3, 0, 3, 7));
    add_pair(pair_of(0, 0, 10, 0, 3, -4, 3, 0));
    // crossing exactly at an end point of the first segment
    add_pair(pair_of(0, 0, 10, 0, 0, -1, 0, 1));
    add_pair(pair_of(0, 0, 10, 0, 10, -1, 10, 1));
    // rounding ties, odd thirds, negative directions
    add_pair(pair_of(0, 0, 1, 0, 0, 0, 0, 0));
    add_pair(pair_of(0, 0, 3, 1, 1, -1, 1, 2));
    add_pair(pair_of(7, 3, -9, -5, -3, 8, 2, -7));
    add_pair(pair_of(1, 0, 0, 0, 0, -1, 1, 2));
    // coordinate extremes, full-range cross products, wrap of the result
    add_pair(pair_of(-32768, -32768, 32767, 32767,
                     -32768, 32767, 32767, -32768));
    add_pair(pair_of(32767, -32768, -32768, 32767,
                     -32768, -32768, 32767, 32767));
    add_pair(pair_of(-32768, 0, 32767, 0, 32767, -32768, 32766, 32767));
    add_pair(pair_of(32767, 32767, 32767, -32768,
                     -32768, 1, 32767, -1));
    add_pair(pair_of(-1, -1, -1, -1, -1, -1, -1, -1));
    add_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 1500; i++) add_pair(random_pair());
    stimulus_done = 1'b1;
  end

  // Driver: bursts of transfers separated by random gaps. A transfer that
  // was not taken at the last rising edge stays on the bus.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled payload
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (pending_pairs.size() != 0) begin
      in_data <= pending_pairs.pop_front();
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern: phases of free flow, of random stalls and of a held stall.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (stall_phase < 100) out_stall <= 1'b0;
    else if (stall_phase < 200) out_stall <= ($urandom_range(0, 3) == 0);
    else if (stall_phase < 220) out_stall <= 1'b1;
    else out_stall <= $urandom_range(0, 1);
  end

  // Input monitor: predict each accepted transfer.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_crossings.insert(expected_crossings.size(), predict_crossing(in_data));
  end

  // Output monitor: compare against the oldest expectation.
  always @(posedge clk) begin
    sgi_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_crossings.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result transfer %p", out_data);
      end else begin
        want = expected_crossings.pop_front();
        if (out_data.hit !== want.hit || out_data.cross_x !== want.cross_x ||
            out_data.cross_y !== want.cross_y) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                     want.hit, want.cross_x, want.cross_y,
                     out_data.hit, out_data.cross_x, out_data.cross_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_segment_intersection: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (stimulus_done && pending_pairs.size() == 0);
    @(posedge clk);
    while (in_valid || expected_crossings.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_crossings.size() == 0) begin
      $display("tb_segment_intersection: PASS");
    end else begin
      $display("tb_segment_intersection: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
